// ===== rtl/mfb_pkg.sv =====
// ----------------------------------------------------------------------------
// mfb_pkg: shared types and constants for the mono frame store refresh block
// Opcodes, command records passed from the front end to the back end, result
// records and the serial byte constants of the display link.
// ----------------------------------------------------------------------------
package mfb_pkg;

  // frame store geometry (fixed)
  localparam int STORE_DEPTH = 1024;
  localparam int STORE_AW    = 10;

  // serial link constants
  localparam logic [7:0] SYNC_BASE    = 8'hF8;
  localparam logic [7:0] NIB_MASK     = 8'hF0;
  localparam logic [7:0] ROW_CMD_BASE = 8'h80;
  localparam logic [7:0] COL_LOW      = 8'h80;
  localparam logic [7:0] COL_HIGH     = 8'h88;
  localparam logic [7:0] FILL_SET     = 8'hFF;
  localparam logic [7:0] FILL_CLR     = 8'h00;
  localparam int         ROW_SPLIT    = 32;

  // input opcodes
  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_FILL  = 2'd1,
    OP_ROW   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // work classes handed to the back end
  typedef enum logic [1:0] {
    K_WRITE,
    K_FILL,
    K_ROW,
    K_STAT
  } cmd_kind_t;

  // back end states
  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_READ,
    S_WRITE,
    S_STAT,
    S_ROW
  } back_state_t;

  // position within a three-byte transfer
  typedef enum logic [1:0] {
    PH_SYNC,
    PH_HIGH,
    PH_LOW
  } phase_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic                status;
    logic                color;
    logic [STORE_AW-1:0] addr;
    logic [2:0]          bit_sel;
    logic [7:0]          row_cmd;
    logic [7:0]          col_cmd;
  } cmd_t;

  typedef struct packed {
    logic [7:0] serial_byte;
    logic       has_byte;
    logic       frame_end;
    logic       status;
    logic       last;
  } res_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

// ===== rtl/mfb_fifo.sv =====
// ----------------------------------------------------------------------------
// mfb_fifo: small register queue
// Holds DEPTH records of DW bits; head record is shown while empty is low.
// ----------------------------------------------------------------------------
module mfb_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output logic          empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  // handshake qualification
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CW'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

endmodule

// ===== rtl/mfb_front.sv =====
// ----------------------------------------------------------------------------
// mfb_front: input decode
// Classifies each item, checks ranges and works out store address, bit
// position and the two row address commands.
// ----------------------------------------------------------------------------
module mfb_front #(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 64
) (
  input  logic          [1:0] opcode,
  input  logic          [7:0] pixel_x,
  input  logic          [6:0] pixel_y,
  input  logic                pixel_color,
  output mfb_pkg::cmd_t       cmd
);
  import mfb_pkg::*;

  localparam logic [8:0] W_LIM = 9'(WIDTH);
  localparam logic [7:0] H_LIM = 8'(HEIGHT);

  logic                x_ok;
  logic                y_ok;
  logic [14:0]         row_prod;
  logic [STORE_AW-1:0] row_base;
  logic                row_hi;
  logic [6:0]          row_off;

  // range checks and row base address (taken modulo the store depth)
  assign x_ok     = ({1'b0, pixel_x} < W_LIM);
  assign y_ok     = ({1'b0, pixel_y} < H_LIM);
  assign row_prod = 15'(pixel_y) * 15'(WIDTH);
  assign row_base = row_prod[STORE_AW+2:3];
  assign row_hi   = ({1'b0, pixel_y} >= 8'(ROW_SPLIT));
  assign row_off  = row_hi ? 7'(pixel_y - 7'(ROW_SPLIT)) : pixel_y;

  // classification
  always_comb begin
    cmd         = '0;
    cmd.color   = pixel_color;
    cmd.bit_sel = pixel_x[2:0];
    cmd.row_cmd = ROW_CMD_BASE | 8'(row_off);
    cmd.col_cmd = row_hi ? COL_HIGH : COL_LOW;
    unique case (op_t'(opcode))
      OP_PIXEL: begin
        cmd.addr   = STORE_AW'(row_base + STORE_AW'(pixel_x[7:3]));
        cmd.kind   = (x_ok && y_ok) ? K_WRITE : K_STAT;
        cmd.status = !(x_ok && y_ok);
      end
      OP_FILL: begin
        cmd.kind = K_FILL;
      end
      OP_ROW: begin
        cmd.addr   = row_base;
        cmd.kind   = y_ok ? K_ROW : K_STAT;
        cmd.status = !y_ok;
      end
      OP_NONE: begin
        cmd.kind = K_STAT;
      end
      default: begin
        cmd.kind = K_STAT;
      end
    endcase
  end

endmodule

// ===== rtl/mfb_back.sv =====
// ----------------------------------------------------------------------------
// mfb_back: execution engine
// Owns the frame store; performs read-modify-write, fill sweeps, the clearing
// pass after reset, and serialises rows into three-byte transfers.
// ----------------------------------------------------------------------------
module mfb_back #(
  parameter int WIDTH = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  mfb_pkg::cmd_t       cmd_head,
  input  logic                cmd_empty,
  output logic                cmd_pop,
  input  logic                res_full,
  output logic                res_push,
  output mfb_pkg::res_t       res,
  output mfb_pkg::back_stat_t bstat
);
  import mfb_pkg::*;

  localparam int            NBYTES   = 2 * (WIDTH / 16);
  localparam int            IW       = $clog2(NBYTES + 2);
  localparam logic [IW-1:0] LAST_IDX = IW'(NBYTES + 1);

  back_state_t         state;
  back_state_t         state_next;
  cmd_t                cur;
  logic [STORE_AW-1:0] sweep_addr;
  logic [7:0]          sweep_val;
  logic                report;
  phase_t              phase;
  logic [IW-1:0]       byte_idx;

  logic [7:0]          store [STORE_DEPTH];
  logic [7:0]          rd_data;
  logic                mem_we;
  logic [STORE_AW-1:0] mem_waddr;
  logic [7:0]          mem_wdata;
  logic                mem_re;
  logic [STORE_AW-1:0] mem_raddr;
  logic [STORE_AW-1:0] data_addr;
  logic [7:0]          bit_mask;
  logic [7:0]          cur_byte;
  logic                row_last;

  assign data_addr = STORE_AW'(cur.addr + STORE_AW'(byte_idx) - STORE_AW'(2));
  assign bit_mask  = 8'h80 >> cur.bit_sel;
  assign row_last  = (phase == PH_LOW) && (byte_idx == LAST_IDX);
  assign bstat.clearing = (state == S_SWEEP) && !report;

  // byte being sent: two commands, then store data
  always_comb begin
    case (byte_idx)
      IW'(0):  cur_byte = cur.row_cmd;
      IW'(1):  cur_byte = cur.col_cmd;
      default: cur_byte = rd_data;
    endcase
  end

  // frame store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= store[mem_raddr];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_SWEEP: begin
        if (sweep_addr == '1) begin
          state_next = report ? S_STAT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (!cmd_empty) begin
          unique case (cmd_head.kind)
            K_WRITE: state_next = S_READ;
            K_FILL:  state_next = S_SWEEP;
            K_ROW:   state_next = S_ROW;
            K_STAT:  state_next = S_STAT;
            default: state_next = S_STAT;
          endcase
        end
      end
      S_READ:  state_next = S_WRITE;
      S_WRITE: if (!res_full) state_next = S_IDLE;
      S_STAT:  if (!res_full) state_next = S_IDLE;
      S_ROW:   if (!res_full && row_last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    res       = '0;
    mem_we    = 1'b0;
    mem_waddr = cur.addr;
    mem_wdata = cur.color ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
    mem_re    = 1'b0;
    mem_raddr = data_addr;
    unique case (state)
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_addr;
        mem_wdata = sweep_val;
      end
      S_IDLE: begin
        cmd_pop = !cmd_empty;
      end
      S_READ: begin
        mem_re    = 1'b1;
        mem_raddr = cur.addr;
      end
      S_WRITE: begin
        mem_we   = !res_full;
        res_push = !res_full;
        res.last = 1'b1;
      end
      S_STAT: begin
        res_push   = !res_full;
        res.status = cur.status;
        res.last   = 1'b1;
      end
      S_ROW: begin
        mem_re        = (phase == PH_SYNC);
        res_push      = !res_full;
        res.has_byte  = 1'b1;
        res.frame_end = (phase == PH_LOW);
        res.last      = row_last;
        case (phase)
          PH_SYNC: res.serial_byte = SYNC_BASE | {6'd0, (byte_idx >= IW'(2)), 1'b0};
          PH_HIGH: res.serial_byte = cur_byte & NIB_MASK;
          default: res.serial_byte = {cur_byte[3:0], 4'd0};
        endcase
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_addr <= '0;
      sweep_val  <= FILL_CLR;
      report     <= 1'b0;
      phase      <= PH_SYNC;
      byte_idx   <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_SWEEP: begin
          sweep_addr <= STORE_AW'(sweep_addr + 1'b1);
        end
        S_IDLE: begin
          if (cmd_pop) begin
            cur        <= cmd_head;
            sweep_addr <= '0;
            sweep_val  <= cmd_head.color ? FILL_SET : FILL_CLR;
            report     <= (cmd_head.kind == K_FILL);
            phase      <= PH_SYNC;
            byte_idx   <= '0;
          end
        end
        S_ROW: begin
          if (res_push) begin
            case (phase)
              PH_SYNC: phase <= PH_HIGH;
              PH_HIGH: phase <= PH_LOW;
              default: begin
                phase    <= PH_SYNC;
                byte_idx <= IW'(byte_idx + 1'b1);
              end
            endcase
          end
        end
        default: begin
          phase <= phase;
        end
      endcase
    end
  end

  // checks
  a_no_result_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> !res_push)
    else $error("result pushed during store sweep");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmd_empty)
    else $error("command popped from empty queue");

  a_end_has_byte: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.frame_end) |-> (res.has_byte && (state == S_ROW)))
    else $error("frame end without a serial byte");

  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> ($past(state) == S_READ || $past(state) == S_WRITE))
    else $error("store write without preceding read");

endmodule

// ===== rtl/mono_framebuffer_spi_refresh.sv =====
// ----------------------------------------------------------------------------
// mono_framebuffer_spi_refresh: 1-bit frame store with serial row refresh
// Pixel writes, store fills and row refreshes; each row goes out as address
// commands and data bytes, every byte split into sync, high and low nibble.
//
//   channel  | handshake        | payload
//   ---------+------------------+--------------------------------------------
//   input    | push / full      | opcode, pixel_x, pixel_y, pixel_color
//   result   | pop / empty      | serial_byte, has_byte, frame_end, status, last
//
// pixel write: queue pop, store read, then store write with a status result
// row refresh: one serial byte per cycle while the result queue is not full
// fill: the store sweep writes one byte per cycle, then a status result follows
// after reset a clearing pass over the whole store holds full high
// a full result queue stalls the back end; the two-entry command queue keeps
// taking items meanwhile
// ----------------------------------------------------------------------------
module mono_framebuffer_spi_refresh #(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] opcode,
  input  logic [7:0] pixel_x,
  input  logic [6:0] pixel_y,
  input  logic       pixel_color,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] serial_byte,
  output logic       has_byte,
  output logic       frame_end,
  output logic       status,
  output logic       last
);
  import mfb_pkg::*;

  cmd_t       cmd_in;
  cmd_t       cmd_head;
  logic       cmd_full;
  logic       cmd_empty;
  logic       cmd_pop;
  res_t       res_in;
  res_t       res_head;
  logic       res_full;
  logic       res_push;
  back_stat_t bstat;

  // input side
  assign full = cmd_full || bstat.clearing;

  mfb_front #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_front (
    .opcode      (opcode),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .cmd         (cmd_in)
  );

  // command queue between front and back
  mfb_fifo #(
    .DW    ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push && !full),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_head),
    .empty (cmd_empty)
  );

  mfb_back #(
    .WIDTH (WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_head  (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in),
    .bstat     (bstat)
  );

  // result queue
  mfb_fifo #(
    .DW    ($bits(res_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_head),
    .empty (empty)
  );

  // result ports
  assign serial_byte = res_head.serial_byte;
  assign has_byte    = res_head.has_byte;
  assign frame_end   = res_head.frame_end;
  assign status      = res_head.status;
  assign last        = res_head.last;

endmodule
